// File: rtl/e2r_pkg.sv
// Shared types and constant functions for the Euler angle to rotation matrix block.
`timescale 1ns / 1ps
package e2r_pkg;

	// Which matrix a beat asks for
	typedef enum logic {
		KIND_I2B = 1'b0,
		KIND_B2I = 1'b1
	} kind_t;

	// Sine of idx steps in a quarter turn of 2^(abits-2) steps, rounded half up to fbits
	function automatic longint sin_q(input int idx, input int abits, input int fbits);
		real ang;
		real val;
		// half pi times idx, halved once per bit of the quarter-turn step count
		ang = 1.57079632679489661923 * real'(idx);
		for (int k = 0; k < abits - 2; k++) begin
			ang = ang * 0.5;
		end
		val = $sin(ang) * real'(64'd1 << fbits);
		return longint'($floor(val + 0.5));
	endfunction

endpackage

// File: rtl/euler_to_rotation_matrix_top.sv
// ZYX Euler angles to direction cosine matrix, five-stage pipeline.
`timescale 1ns / 1ps
// Takes roll, pitch and yaw as binary angles (2^ANGLE_BITS units per turn) and
// returns the nine entries of the ZYX inertial-to-body rotation matrix in signed
// Q1.FRAC_BITS, or its transpose when kind is set. One beat is accepted every
// cycle while the output is not stalled; it passes five register stages on its
// way to the outputs: table read, sign fix, first products, second products,
// sum and saturate. A stalled output holds the whole pipeline. The sine table
// is a quarter wave of 2^(ANGLE_BITS-2)+1 entries, one copy per angle, each
// read for sine and cosine in the same cycle.
module euler_to_rotation_matrix_top #(
	parameter int ANGLE_BITS = 12,
	parameter int FRAC_BITS  = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic [ANGLE_BITS-1:0]        roll_angle,
	input  logic [ANGLE_BITS-1:0]        pitch_angle,
	input  logic [ANGLE_BITS-1:0]        yaw_angle,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [FRAC_BITS+1:0]  m00,
	output logic signed [FRAC_BITS+1:0]  m01,
	output logic signed [FRAC_BITS+1:0]  m02,
	output logic signed [FRAC_BITS+1:0]  m10,
	output logic signed [FRAC_BITS+1:0]  m11,
	output logic signed [FRAC_BITS+1:0]  m12,
	output logic signed [FRAC_BITS+1:0]  m20,
	output logic signed [FRAC_BITS+1:0]  m21,
	output logic signed [FRAC_BITS+1:0]  m22
);
	localparam int W = FRAC_BITS + 2;
	localparam logic signed [W:0] ONE_X  = (W+1)'(1 << FRAC_BITS);
	localparam logic signed [W:0] MONE_X = -ONE_X;
	localparam logic signed [W-1:0] ONE  = W'(1 << FRAC_BITS);

	typedef logic signed [W-1:0] fix_t;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic kind_s1, kind_s2, kind_s3, kind_s4;

	// Whole pipeline moves when the output register is free or being taken
	assign en        = !v_s5 || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: table reads
	logic [FRAC_BITS:0] sph_m, cph_m, sth_m, cth_m, sps_m, cps_m;
	logic sph_n, cph_n, sth_n, cth_n, sps_n, cps_n;

	e2r_sincos_rom #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_rom_roll (
		.clk(clk), .en(en), .angle(roll_angle),
		.sin_mag(sph_m), .cos_mag(cph_m), .sin_neg(sph_n), .cos_neg(cph_n)
	);
	e2r_sincos_rom #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_rom_pitch (
		.clk(clk), .en(en), .angle(pitch_angle),
		.sin_mag(sth_m), .cos_mag(cth_m), .sin_neg(sth_n), .cos_neg(cth_n)
	);
	e2r_sincos_rom #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_rom_yaw (
		.clk(clk), .en(en), .angle(yaw_angle),
		.sin_mag(sps_m), .cos_mag(cps_m), .sin_neg(sps_n), .cos_neg(cps_n)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind;
			kind_s2 <= kind_s1;
			kind_s3 <= kind_s2;
			kind_s4 <= kind_s3;
		end
	end

	// Stage 2: apply quadrant signs
	fix_t sph_s2, cph_s2, sth_s2, cth_s2, sps_s2, cps_s2;

	function automatic fix_t signed_val(input logic [FRAC_BITS:0] mag, input logic neg);
		fix_t v;
		v = fix_t'({1'b0, mag});
		return neg ? -v : v;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			sph_s2 <= signed_val(sph_m, sph_n);
			cph_s2 <= signed_val(cph_m, cph_n);
			sth_s2 <= signed_val(sth_m, sth_n);
			cth_s2 <= signed_val(cth_m, cth_n);
			sps_s2 <= signed_val(sps_m, sps_n);
			cps_s2 <= signed_val(cps_m, cps_n);
		end
	end

	// Stage 3: two-factor products
	fix_t cc_s3, cs_s3, ss_th_s3, cs_th_s3, cphsps_s3, cphcps_s3;
	fix_t sphcth_s3, sphsps_s3, sphcps_s3, cphcth_s3;
	fix_t sth_s3, sps_s3, cps_s3;

	e2r_qmul #(.FRAC_BITS(FRAC_BITS)) u_m0 (.clk(clk), .en(en), .a(cth_s2), .b(cps_s2), .p(cc_s3));
	e2r_qmul #(.FRAC_BITS(FRAC_BITS)) u_m1 (.clk(clk), .en(en), .a(cth_s2), .b(sps_s2), .p(cs_s3));
	e2r_qmul #(.FRAC_BITS(FRAC_BITS)) u_m2 (.clk(clk), .en(en), .a(sph_s2), .b(sth_s2), .p(ss_th_s3));
	e2r_qmul #(.FRAC_BITS(FRAC_BITS)) u_m3 (.clk(clk), .en(en), .a(cph_s2), .b(sth_s2), .p(cs_th_s3));
	e2r_qmul #(.FRAC_BITS(FRAC_BITS)) u_m4 (.clk(clk), .en(en), .a(cph_s2), .b(sps_s2), .p(cphsps_s3));
	e2r_qmul #(.FRAC_BITS(FRAC_BITS)) u_m5 (.clk(clk), .en(en), .a(cph_s2), .b(cps_s2), .p(cphcps_s3));
	e2r_qmul #(.FRAC_BITS(FRAC_BITS)) u_m6 (.clk(clk), .en(en), .a(sph_s2), .b(cth_s2), .p(sphcth_s3));
	e2r_qmul #(.FRAC_BITS(FRAC_BITS)) u_m7 (.clk(clk), .en(en), .a(sph_s2), .b(sps_s2), .p(sphsps_s3));
	e2r_qmul #(.FRAC_BITS(FRAC_BITS)) u_m8 (.clk(clk), .en(en), .a(sph_s2), .b(cps_s2), .p(sphcps_s3));
	e2r_qmul #(.FRAC_BITS(FRAC_BITS)) u_m9 (.clk(clk), .en(en), .a(cph_s2), .b(cth_s2), .p(cphcth_s3));

	always_ff @(posedge clk) begin
		if (en) begin
			sth_s3 <= sth_s2;
			sps_s3 <= sps_s2;
			cps_s3 <= cps_s2;
		end
	end

	// Stage 4: third factor on the pitch terms, carry the rest
	fix_t t10_s4, t11_s4, t20_s4, t21_s4;
	fix_t cc_s4, cs_s4, cphsps_s4, cphcps_s4, sphcth_s4, sphsps_s4, sphcps_s4, cphcth_s4;
	fix_t sth_s4;

	e2r_qmul #(.FRAC_BITS(FRAC_BITS)) u_t10 (.clk(clk), .en(en), .a(ss_th_s3), .b(cps_s3), .p(t10_s4));
	e2r_qmul #(.FRAC_BITS(FRAC_BITS)) u_t11 (.clk(clk), .en(en), .a(ss_th_s3), .b(sps_s3), .p(t11_s4));
	e2r_qmul #(.FRAC_BITS(FRAC_BITS)) u_t20 (.clk(clk), .en(en), .a(cs_th_s3), .b(cps_s3), .p(t20_s4));
	e2r_qmul #(.FRAC_BITS(FRAC_BITS)) u_t21 (.clk(clk), .en(en), .a(cs_th_s3), .b(sps_s3), .p(t21_s4));

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s4     <= cc_s3;
			cs_s4     <= cs_s3;
			cphsps_s4 <= cphsps_s3;
			cphcps_s4 <= cphcps_s3;
			sphcth_s4 <= sphcth_s3;
			sphsps_s4 <= sphsps_s3;
			sphcps_s4 <= sphcps_s3;
			cphcth_s4 <= cphcth_s3;
			sth_s4    <= sth_s3;
		end
	end

	// Stage 5: sums, saturation and optional transpose
	function automatic fix_t sat(input logic signed [W:0] v);
		if (v > ONE_X) begin
			return ONE;
		end else if (v < MONE_X) begin
			return -ONE;
		end
		return v[W-1:0];
	endfunction

	fix_t r00, r01, r02, r10, r11, r12, r20, r21, r22;

	always_comb begin
		r00 = sat((W+1)'(cc_s4));
		r01 = sat((W+1)'(cs_s4));
		r02 = sat(-(W+1)'(sth_s4));
		r10 = sat((W+1)'(t10_s4) - (W+1)'(cphsps_s4));
		r11 = sat((W+1)'(t11_s4) + (W+1)'(cphcps_s4));
		r12 = sat((W+1)'(sphcth_s4));
		r20 = sat((W+1)'(t20_s4) + (W+1)'(sphsps_s4));
		r21 = sat((W+1)'(t21_s4) - (W+1)'(sphcps_s4));
		r22 = sat((W+1)'(cphcth_s4));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m00 <= r00;
			m11 <= r11;
			m22 <= r22;
			if (kind_s4 == e2r_pkg::KIND_B2I) begin
				m01 <= r10; m02 <= r20; m10 <= r01;
				m12 <= r21; m20 <= r02; m21 <= r12;
			end else begin
				m01 <= r01; m02 <= r02; m10 <= r10;
				m12 <= r12; m20 <= r20; m21 <= r21;
			end
		end
	end

	// An accepted beat always lands in the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted beat did not enter stage 1");

	// A stall freezes the valid chain
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5}))
		else $error("valid chain moved during stall");

	// Two delivered entries, m10 and m11, stay within plus or minus one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (m11 <= ONE) && (m11 >= -ONE) && (m10 <= ONE) && (m10 >= -ONE))
		else $error("matrix entry out of range");
endmodule

// File: rtl/e2r_sincos_rom.sv
// Quarter-wave sine table with two registered reads: sine and cosine of one angle.
`timescale 1ns / 1ps
module e2r_sincos_rom #(
	parameter int ANGLE_BITS = 12,
	parameter int FRAC_BITS  = 14
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [ANGLE_BITS-1:0] angle,
	output logic [FRAC_BITS:0]    sin_mag,
	output logic [FRAC_BITS:0]    cos_mag,
	output logic                  sin_neg,
	output logic                  cos_neg
);
	localparam int AW    = ANGLE_BITS - 1;
	localparam int DEPTH = (1 << (ANGLE_BITS - 2)) + 1;
	localparam logic [AW-1:0] QUARTER = AW'(1 << (ANGLE_BITS - 2));

	typedef logic [FRAC_BITS:0] tab_t [DEPTH];

	function automatic tab_t build_tab();
		tab_t t;
		for (int i = 0; i < DEPTH; i++) begin
			t[i] = (FRAC_BITS + 1)'(e2r_pkg::sin_q(i, ANGLE_BITS, FRAC_BITS));
		end
		return t;
	endfunction

	localparam tab_t TAB = build_tab();

	logic [ANGLE_BITS-1:0] cos_ang;
	logic [AW-1:0]         sin_r;
	logic [AW-1:0]         cos_r;
	logic [AW-1:0]         sin_idx;
	logic [AW-1:0]         cos_idx;

	// Fold each angle into the first quadrant; cosine is sine a quarter turn on
	always_comb begin
		cos_ang = angle + ANGLE_BITS'(1 << (ANGLE_BITS - 2));
		sin_r   = {1'b0, angle[ANGLE_BITS-3:0]};
		cos_r   = {1'b0, cos_ang[ANGLE_BITS-3:0]};
		sin_idx = angle[ANGLE_BITS-2]   ? (QUARTER - sin_r) : sin_r;
		cos_idx = cos_ang[ANGLE_BITS-2] ? (QUARTER - cos_r) : cos_r;
	end

	// Registered table reads
	always_ff @(posedge clk) begin
		if (en) begin
			sin_mag <= TAB[sin_idx];
			cos_mag <= TAB[cos_idx];
			sin_neg <= angle[ANGLE_BITS-1];
			cos_neg <= cos_ang[ANGLE_BITS-1];
		end
	end
endmodule

// File: rtl/e2r_qmul.sv
// Registered fixed-point multiply, rounded half up back to the operand format.
`timescale 1ns / 1ps
module e2r_qmul #(
	parameter int FRAC_BITS = 14
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [FRAC_BITS+1:0]  a,
	input  logic signed [FRAC_BITS+1:0]  b,
	output logic signed [FRAC_BITS+1:0]  p
);
	localparam int W = FRAC_BITS + 2;

	logic signed [2*W-1:0] prod;
	logic signed [2*W-1:0] rnd;

	always_comb begin
		prod = a * b;
		rnd  = prod + (2*W)'(1 << (FRAC_BITS - 1));
	end

	// floor of the rounded product; the magnitude never exceeds one
	always_ff @(posedge clk) begin
		if (en) begin
			p <= rnd[FRAC_BITS+W-1:FRAC_BITS];
		end
	end
endmodule

// File: tb/tb.sv
// Self-checking testbench for the Euler angle to rotation matrix pipeline.
`timescale 1ns / 1ps
module tb;

	localparam int ABITS = 12;
	localparam int FBITS = 14;
	localparam int QSTEPS = 1 << (ABITS - 2);
	localparam longint UNIT = 64'sd1 << FBITS;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		e2r_pkg::kind_t   kind;
		logic [ABITS-1:0] roll;
		logic [ABITS-1:0] pitch;
		logic [ABITS-1:0] yaw;
	} angles_t;

	typedef logic signed [FBITS+1:0] entry_t;
	typedef struct {
		entry_t m [9];
	} dcm_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = 1'b0;
	logic [ABITS-1:0] roll_angle = '0;
	logic [ABITS-1:0] pitch_angle = '0;
	logic [ABITS-1:0] yaw_angle = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	entry_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

	angles_t pending_angles [$];
	dcm_t    dcm_expected [$];
	longint  quarter_sine [0:QSTEPS];
	int      errors = 0;
	int      beats_in = 0;
	int      idle_cycles = 0;

	euler_to_rotation_matrix_top #(.ANGLE_BITS(ABITS), .FRAC_BITS(FBITS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
		.out_valid(out_valid), .out_ready(out_ready),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22)
	);

	always #2 clk = ~clk;

	// Sine of a binary angle in Q1.14, quadrant folded onto the quarter table
	function automatic longint sine_of(input logic [ABITS-1:0] a);
		logic [1:0] quad;
		int         r;
		longint     mag;
		quad = a[ABITS-1:ABITS-2];
		r = int'(a[ABITS-3:0]);
		mag = quad[0] ? quarter_sine[QSTEPS - r] : quarter_sine[r];
		return quad[1] ? -mag : mag;
	endfunction

	// Product rounded half up back to Q1.14
	function automatic longint fx_mul(input longint a, input longint b);
		return (a * b + (64'sd1 <<< (FBITS - 1))) >>> FBITS;
	endfunction

	function automatic entry_t clamp_unit(input longint v);
		if (v > UNIT) v = UNIT;
		if (v < -UNIT) v = -UNIT;
		return entry_t'(v);
	endfunction

	// Direction cosine matrix of one angle triple, transposed on request
	function automatic dcm_t predict_dcm(input angles_t x);
		longint sph, cph, sth, cth, sps, cps;
		longint r [3][3];
		dcm_t   d;
		sph = sine_of(x.roll);
		cph = sine_of(x.roll + ABITS'(QSTEPS));
		sth = sine_of(x.pitch);
		cth = sine_of(x.pitch + ABITS'(QSTEPS));
		sps = sine_of(x.yaw);
		cps = sine_of(x.yaw + ABITS'(QSTEPS));
		r[0][0] = fx_mul(cth, cps);
		r[0][1] = fx_mul(cth, sps);
		r[0][2] = -sth;
		r[1][0] = fx_mul(fx_mul(sph, sth), cps) - fx_mul(cph, sps);
		r[1][1] = fx_mul(fx_mul(sph, sth), sps) + fx_mul(cph, cps);
		r[1][2] = fx_mul(sph, cth);
		r[2][0] = fx_mul(fx_mul(cph, sth), cps) + fx_mul(sph, sps);
		r[2][1] = fx_mul(fx_mul(cph, sth), sps) - fx_mul(sph, cps);
		r[2][2] = fx_mul(cph, cth);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				d.m[i*3+j] = clamp_unit((x.kind == e2r_pkg::KIND_B2I) ? r[j][i] : r[i][j]);
		return d;
	endfunction

	// Mostly no gap, some short, a few long
	function automatic int pick_gap(input bit busy_run);
		int p;
		if (busy_run) return 0;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void add_item(input bit k, input int r, input int p, input int y);
		angles_t x;
		x.kind = e2r_pkg::kind_t'(k);
		x.roll = ABITS'(r);
		x.pitch = ABITS'(p);
		x.yaw = ABITS'(y);
		pending_angles.push_back(x);
	endfunction

	// Angle near a quadrant boundary, or anywhere
	function automatic int pick_angle();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 3) * QSTEPS + $urandom_range(0, 6) - 3;
		return $urandom_range(0, (1 << ABITS) - 1);
	endfunction

	// Driver: offers queued beats with random gaps
	int  send_gap = 0;
	bit  send_busy = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		logic    keep;
		angles_t x;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				dcm_expected.push_back(predict_dcm(
					'{e2r_pkg::kind_t'(kind), roll_angle, pitch_angle, yaw_angle}));
				beats_in++;
			end
			keep = in_valid && !in_ready;
			if (!keep) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_angles.size() > 0) begin
					x = pending_angles.pop_front();
					kind <= x.kind;
					roll_angle <= x.roll;
					pitch_angle <= x.pitch;
					yaw_angle <= x.yaw;
					keep = 1'b1;
					if ($urandom_range(0, 99) == 0) send_busy = !send_busy;
					send_gap = pick_gap(send_busy);
				end
			end
			in_valid <= keep;
		end
	end

	// Monitor: random back-pressure, one long hold-off, compare against oldest
	int  recv_gap = 0;
	int  hold_off = 0;
	bit  hold_done = 1'b0;
	bit  recv_busy = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		dcm_t   want;
		entry_t got [9];
		bit     bad;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
				if (dcm_expected.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result beat at %0t", $realtime);
				end else begin
					want = dcm_expected.pop_front();
					bad = 1'b0;
					for (int i = 0; i < 9; i++)
						if (got[i] !== want.m[i]) bad = 1'b1;
					if (bad) begin
						errors++;
						if (errors <= 10)
							for (int i = 0; i < 9; i++)
								$display("m%0d%0d expected %0d got %0d", i / 3, i % 3,
									want.m[i], got[i]);
					end
				end
			end
			if (!hold_done && beats_in >= 600) begin
				hold_done = 1'b1;
				hold_off = 300;
			end
			if (hold_off > 0) begin
				hold_off--;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 99) == 0) recv_busy = !recv_busy;
				recv_gap = pick_gap(recv_busy);
			end
		end
	end

	// Watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i <= QSTEPS; i++)
			quarter_sine[i] = longint'($floor($sin(3.14159265358979323846 * i /
				(2.0 * QSTEPS)) * real'(UNIT) + 0.5));

		// Directed: quadrant points, wrap, extremes, both kinds
		add_item(0, 0, 0, 0);
		add_item(1, 0, 0, 0);
		add_item(0, 4095, 4095, 4095);
		add_item(1, 4095, 4095, 4095);
		add_item(0, 1024, 0, 0);
		add_item(0, 0, 1024, 0);
		add_item(0, 0, 0, 1024);
		add_item(1, 2048, 2048, 2048);
		add_item(0, 3072, 3072, 3072);
		add_item(1, 3072, 1024, 2048);
		add_item(0, 0, 3072, 1024);
		add_item(1, 1024, 3072, 0);
		add_item(0, 512, 512, 512);
		add_item(1, 512, 1536, 2560);
		add_item(0, 1, 2047, 2049);
		add_item(1, 1023, 1025, 3071);
		add_item(0, 2730, 1365, 3413);
		add_item(1, 2730, 1365, 3413);
		add_item(0, 4095, 0, 1);
		add_item(1, 1, 4095, 0);

		// Random triples
		for (int n = 0; n < 1950; n++)
			add_item($urandom_range(0, 1), pick_angle(), pick_angle(), pick_angle());

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (pending_angles.size() != 0 || in_valid || dcm_expected.size() != 0);
		repeat (20) @(posedge clk);

		if (errors == 0 && dcm_expected.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
